/* rtl/tis_pkg.sv */
// ----------------------------------------------------------------------------
// tis_pkg
// Shared widths for the triangle isoline segment pipeline.
// ----------------------------------------------------------------------------
package tis_pkg;

  // Q16.16 coordinate and scalar width
  localparam int VW = 32;
  // magnitude of a scalar difference, also the divider remainder width
  localparam int RW = 32;
  // quotient bits of the Q1.31 interpolation coefficient (always below 1.0)
  localparam int QW = 31;

endpackage

/* rtl/tis_div.sv */
// ----------------------------------------------------------------------------
// tis_div
// Pipelined restoring divider, one quotient bit per stage, two divisions
// sharing one numerator. Computes floor(num * 2^QW / den) for num < den and
// carries a side payload in step with the quotients.
// ----------------------------------------------------------------------------
module tis_div import tis_pkg::*; #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] num,
  input  logic [RW-1:0] den_a,
  input  logic [RW-1:0] den_b,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  output logic [QW-1:0] quo_a,
  output logic [QW-1:0] quo_b,
  output logic [PW-1:0] pay_out
);

  logic          vld   [0:QW];
  logic [RW-1:0] rem_a [0:QW];
  logic [RW-1:0] rem_b [0:QW];
  logic [RW-1:0] dva   [0:QW];
  logic [RW-1:0] dvb   [0:QW];
  logic [QW-1:0] qa    [0:QW];
  logic [QW-1:0] qb    [0:QW];
  logic [PW-1:0] pay   [0:QW];

  assign vld[0]   = in_valid;
  assign rem_a[0] = num;
  assign rem_b[0] = num;
  assign dva[0]   = den_a;
  assign dvb[0]   = den_b;
  assign qa[0]    = '0;
  assign qb[0]    = '0;
  assign pay[0]   = pay_in;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [RW:0]   sh_a, sh_b;
    logic          ge_a, ge_b;
    logic [RW:0]   df_a, df_b;
    logic [RW-1:0] rem_a_nxt, rem_b_nxt;

    // shift, trial subtract, keep or restore
    always_comb begin
      sh_a = {rem_a[g], 1'b0};
      sh_b = {rem_b[g], 1'b0};
      ge_a = sh_a >= {1'b0, dva[g]};
      ge_b = sh_b >= {1'b0, dvb[g]};
      df_a = sh_a - {1'b0, dva[g]};
      df_b = sh_b - {1'b0, dvb[g]};
      rem_a_nxt = ge_a ? df_a[RW-1:0] : sh_a[RW-1:0];
      rem_b_nxt = ge_b ? df_b[RW-1:0] : sh_b[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[g+1] <= rem_a_nxt;
        rem_b[g+1] <= rem_b_nxt;
        dva[g+1]   <= dva[g];
        dvb[g+1]   <= dvb[g];
        qa[g+1]    <= {qa[g][QW-2:0], ge_a};
        qb[g+1]    <= {qb[g][QW-2:0], ge_b};
        pay[g+1]   <= pay[g];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo_a     = qa[QW];
  assign quo_b     = qb[QW];
  assign pay_out   = pay[QW];

endmodule

/* rtl/triangle_isoline_segment_top.sv */
// ----------------------------------------------------------------------------
// triangle_isoline_segment_top
// Isoline segment through one triangle per request, marching-triangles style.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_data: iso_level, Q16.16
//  in      | in  | in_tvalid / in_tready  | in_tdata: 3 vertices + 3 scalars
//  out     | out | out_tvalid / out_tready| out_tdata: segment, out_tuser: draw
//
// One request per cycle while the output is not stalled; the 31-stage
// restoring divider forms the Q1.31 interpolation coefficient.
// Reset (rst_n low, synchronous) empties the pipeline and clears iso_level.
// A stall on the output freezes the whole pipeline in place; nothing is lost.
// ----------------------------------------------------------------------------
module triangle_isoline_segment_top import tis_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz, scalar_a, scalar_b, scalar_c
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z,
  // first_edge_slot, second_edge_slot, 4 zero bits
  output logic [199:0] out_tdata,
  // draw
  output logic         out_tuser
);

  typedef logic signed [VW-1:0] crd_t;

  typedef struct packed {
    logic          draw;
    logic          vtx;
    logic [1:0]    slot1;
    logic [1:0]    slot2;
    crd_t [2:0]    p2;
    crd_t [2:0]    p3;
    logic [2:0][VW-1:0] mag_a;
    logic [2:0]    neg_a;
    logic [2:0][VW-1:0] mag_b;
    logic [2:0]    neg_b;
  } pay_t;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;
  assign cfg_ready = rst_n;

  // configuration register
  logic signed [VW-1:0] level_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cfg_valid) begin
      level_r <= cfg_data;
    end
  end

  // stage 1: input register
  logic s1_valid_r;
  crd_t s1_p_r [0:2][0:2];
  crd_t s1_d_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int n = 0; n < 3; n++) begin
          s1_p_r[k][n] <= in_tdata[(k*3+n)*32 +: 32];
        end
        s1_d_r[k] <= in_tdata[(9+k)*32 +: 32];
      end
    end
  end

  // stage 1 logic: side test and rotation select
  logic signed [VW:0] dl [0:2];
  logic [2:0] pos, neg;
  logic       sel_draw, sel_vtx;
  logic [1:0] sel_i1, sel_i2, sel_i3;

  always_comb begin
    logic [1:0] j2, j3;
    logic       opp12, opp23;
    for (int k = 0; k < 3; k++) begin
      dl[k]  = {s1_d_r[k][VW-1], s1_d_r[k]} - {level_r[VW-1], level_r};
      neg[k] = dl[k][VW];
      pos[k] = !dl[k][VW] && (dl[k] != '0);
    end
    sel_draw = 1'b0;
    sel_vtx  = 1'b0;
    sel_i1   = 2'd0;
    sel_i2   = 2'd1;
    sel_i3   = 2'd2;
    for (int k = 0; k < 3; k++) begin
      j2 = (k == 2) ? 2'd0 : 2'(k + 1);
      j3 = (k == 0) ? 2'd2 : 2'(k - 1);
      opp12 = (pos[k] && neg[j2]) || (neg[k] && pos[j2]);
      opp23 = (pos[j2] && neg[j3]) || (neg[j2] && pos[j3]);
      if (!sel_draw && opp12 && (opp23 || (!pos[j3] && !neg[j3]))) begin
        sel_draw = 1'b1;
        sel_vtx  = !opp23;
        sel_i1   = 2'(k);
        sel_i2   = j2;
        sel_i3   = j3;
      end
    end
  end

  // stage 2 register: selected rotation
  logic       s2_valid_r;
  logic       s2_draw_r, s2_vtx_r;
  logic [1:0] s2_slot1_r, s2_slot2_r;
  crd_t       s2_p1_r [0:2];
  crd_t       s2_p2_r [0:2];
  crd_t       s2_p3_r [0:2];
  crd_t       s2_d1_r, s2_d2_r, s2_d3_r;
  logic [RW-1:0] s2_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_draw_r  <= sel_draw;
      s2_vtx_r   <= sel_vtx;
      s2_slot1_r <= sel_i1;
      s2_slot2_r <= sel_vtx ? sel_i3 : sel_i2;
      for (int n = 0; n < 3; n++) begin
        s2_p1_r[n] <= s1_p_r[sel_i1][n];
        s2_p2_r[n] <= s1_p_r[sel_i2][n];
        s2_p3_r[n] <= s1_p_r[sel_i3][n];
      end
      s2_d1_r  <= s1_d_r[sel_i1];
      s2_d2_r  <= s1_d_r[sel_i2];
      s2_d3_r  <= s1_d_r[sel_i3];
      s2_num_r <= dl[sel_i2][VW] ? RW'(-dl[sel_i2]) : RW'(dl[sel_i2]);
    end
  end

  // stage 2 logic: divisors and coordinate deltas
  logic signed [VW:0] dd_a, dd_b;
  logic [RW-1:0] den_a, den_b;
  pay_t div_in;

  always_comb begin
    logic signed [VW:0] dx_a, dx_b;
    dd_a  = {s2_d2_r[VW-1], s2_d2_r} - {s2_d1_r[VW-1], s2_d1_r};
    dd_b  = {s2_d2_r[VW-1], s2_d2_r} - {s2_d3_r[VW-1], s2_d3_r};
    den_a = dd_a[VW] ? RW'(-dd_a) : RW'(dd_a);
    den_b = dd_b[VW] ? RW'(-dd_b) : RW'(dd_b);
    div_in.draw  = s2_draw_r;
    div_in.vtx   = s2_vtx_r;
    div_in.slot1 = s2_slot1_r;
    div_in.slot2 = s2_slot2_r;
    for (int n = 0; n < 3; n++) begin
      dx_a = {s2_p1_r[n][VW-1], s2_p1_r[n]} - {s2_p2_r[n][VW-1], s2_p2_r[n]};
      dx_b = {s2_p3_r[n][VW-1], s2_p3_r[n]} - {s2_p2_r[n][VW-1], s2_p2_r[n]};
      div_in.p2[n]    = s2_p2_r[n];
      div_in.p3[n]    = s2_p3_r[n];
      div_in.neg_a[n] = dx_a[VW];
      div_in.neg_b[n] = dx_b[VW];
      div_in.mag_a[n] = dx_a[VW] ? VW'(-dx_a) : VW'(dx_a);
      div_in.mag_b[n] = dx_b[VW] ? VW'(-dx_b) : VW'(dx_b);
    end
  end

  // stage 3: divider pipeline
  logic          dv_valid;
  logic [QW-1:0] c_a, c_b;
  pay_t          dv_pay;

  tis_div #(
    .PW ($bits(pay_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_valid_r),
    .num       (s2_num_r),
    .den_a     (den_a),
    .den_b     (den_b),
    .pay_in    (div_in),
    .out_valid (dv_valid),
    .quo_a     (c_a),
    .quo_b     (c_b),
    .pay_out   (dv_pay)
  );

  // multiply stage: |delta| * c >> 31
  logic          m_valid_r;
  pay_t          m_pay_r;
  logic [VW-1:0] m_qa_r [0:2];
  logic [VW-1:0] m_qb_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [VW+QW-1:0] pa, pb;
    if (en) begin
      m_pay_r <= dv_pay;
      for (int n = 0; n < 3; n++) begin
        pa = dv_pay.mag_a[n] * c_a;
        pb = dv_pay.mag_b[n] * c_b;
        m_qa_r[n] <= pa[VW+QW-1:QW];
        m_qb_r[n] <= pb[VW+QW-1:QW];
      end
    end
  end

  // add stage: endpoints from p2 +- t
  logic       a_valid_r;
  logic       a_draw_r;
  logic [1:0] a_slot1_r, a_slot2_r;
  crd_t       a_st_r [0:2];
  crd_t       a_en_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [VW:0] sa, sb;
    if (en) begin
      a_draw_r  <= m_pay_r.draw;
      a_slot1_r <= m_pay_r.draw ? m_pay_r.slot1 : 2'd0;
      a_slot2_r <= m_pay_r.draw ? m_pay_r.slot2 : 2'd0;
      for (int n = 0; n < 3; n++) begin
        sa = m_pay_r.neg_a[n]
           ? {m_pay_r.p2[n][VW-1], m_pay_r.p2[n]} - {1'b0, m_qa_r[n]}
           : {m_pay_r.p2[n][VW-1], m_pay_r.p2[n]} + {1'b0, m_qa_r[n]};
        sb = m_pay_r.neg_b[n]
           ? {m_pay_r.p2[n][VW-1], m_pay_r.p2[n]} - {1'b0, m_qb_r[n]}
           : {m_pay_r.p2[n][VW-1], m_pay_r.p2[n]} + {1'b0, m_qb_r[n]};
        if (!m_pay_r.draw) begin
          a_st_r[n] <= '0;
          a_en_r[n] <= '0;
        end else begin
          a_st_r[n] <= sa[VW-1:0];
          a_en_r[n] <= m_pay_r.vtx ? m_pay_r.p3[n] : sb[VW-1:0];
        end
      end
    end
  end

  // output stage: midpoint for a negative level
  logic       o_draw_r;
  logic [1:0] o_slot1_r, o_slot2_r;
  crd_t       o_st_r [0:2];
  crd_t       o_en_r [0:2];
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [VW:0] sm;
    if (en) begin
      o_draw_r  <= a_draw_r;
      o_slot1_r <= a_slot1_r;
      o_slot2_r <= a_slot2_r;
      for (int n = 0; n < 3; n++) begin
        sm = {a_st_r[n][VW-1], a_st_r[n]} + {a_en_r[n][VW-1], a_en_r[n]};
        o_st_r[n] <= a_st_r[n];
        o_en_r[n] <= (a_draw_r && level_r[VW-1]) ? sm[VW:1] : a_en_r[n];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_draw_r;
  assign out_tdata  = {4'b0000, o_slot2_r, o_slot1_r,
                       o_en_r[2], o_en_r[1], o_en_r[0],
                       o_st_r[2], o_st_r[1], o_st_r[0]};

endmodule
